@@ design/wbps_pkg.sv @@
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 6;
    localparam int MATCH_OFF_W = 32;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0  = 3'd0,
        REG_PATTERN_1  = 3'd1,
        REG_PATTERN_2  = 3'd2,
        REG_PATTERN_3  = 3'd3,
        REG_WILDCARD   = 3'd4,
        REG_LENGTH     = 3'd5,
        REG_FIND_ALL   = 3'd6
    } cfg_reg_t;

    // One result word as it travels to the output buffer.
    typedef struct packed {
        logic                   any_found;
        logic                   section_end;
        logic [MATCH_OFF_W-1:0] match_offset;
        logic                   match_valid;
    } result_t;

endpackage

`default_nettype wire

@@ design/wbps_cell.sv @@
// One scanner cell: one pattern byte and the partial-match bit for its prefix.
`default_nettype none

module wbps_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic       clear,
    input  wire logic [7:0] pattern_byte,
    input  wire logic       wild,
    input  wire logic       in_use,
    input  wire logic [7:0] data_byte,
    input  wire logic       prev_bit,
    output logic            cur_bit,
    output logic            state_bit
);

    logic state_reg;
    logic state_next;
    logic hit;

    assign hit     = in_use & (wild | (pattern_byte == data_byte));
    assign cur_bit = prev_bit & hit;

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = clear ? 1'b0 : cur_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state_bit = state_reg;

endmodule

`default_nettype wire

@@ design/wbps_out_buf.sv @@
// Output register with a skid stage so the scanner keeps taking bytes under backpressure.
`default_nettype none

module wbps_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire wbps_pkg::result_t push_data,
    output logic                  can_accept,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wbps_pkg::result_t     out_data
);

    import wbps_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop        = out_valid_reg & out_ready;
    assign can_accept = ~skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // No push can arrive while the skid stage is full.
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ design/wildcard_byte_pattern_scanner_unit.sv @@
// A result word is registered into the output buffer on the edge that accepts its byte.
// Throughput: one byte per cycle while the skid stage is empty; all cells update at once.
// A two-entry output buffer lets bytes keep flowing while one result waits downstream.
// Reset clears the scan state, the output buffer and the registers to their reset values
// (pattern length 1, all else zero); there is no clearing pass.
`default_nettype none

module wildcard_byte_pattern_scanner_unit #(
    parameter int PATTERN_MAX  = 32,
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // data_byte
    input  wire logic                            s_tlast,  // last_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // match_valid [0], match_offset [32:1], any_found [33], zeros [39:34]
    output logic [wbps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast   // section_end
);

    import wbps_pkg::*;

    localparam logic [LEN_W-1:0] PMAX_LEN = LEN_W'(PATTERN_MAX);

    logic [CFG_DATA_W-1:0]  pattern_reg [4];
    logic [31:0]            wildcard_reg;
    logic [LEN_W-1:0]       length_reg;
    logic                   find_all_reg;

    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic                    found_reg;
    logic                    found_next;

    logic [LEN_W-1:0]        eff_len;
    logic [PATTERN_MAX-1:0]  in_use;
    logic [PATTERN_MAX-1:0]  is_top;
    logic [PATTERN_MAX-1:0]  cur_bits;
    logic [PATTERN_MAX-1:0]  state_bits;
    logic [PATTERN_MAX:0]    chain;

    logic                    accept;
    logic                    full_match;
    logic                    report;
    logic                    clear;
    logic [OFFSET_WIDTH-1:0] start_off;
    logic [OFFSET_WIDTH+MATCH_OFF_W-1:0] start_ext;
    result_t                 res;
    result_t                 out_res;
    logic                    buf_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pattern_reg[k] <= '0;
            end
            wildcard_reg <= '0;
            length_reg   <= LEN_W'(1);
            find_all_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_0: pattern_reg[0] <= cfg_wdata;
                REG_PATTERN_1: pattern_reg[1] <= cfg_wdata;
                REG_PATTERN_2: pattern_reg[2] <= cfg_wdata;
                REG_PATTERN_3: pattern_reg[3] <= cfg_wdata;
                REG_WILDCARD:  wildcard_reg   <= cfg_wdata[31:0];
                REG_LENGTH:    length_reg     <= cfg_wdata[LEN_W-1:0];
                REG_FIND_ALL:  find_all_reg   <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // A length of zero acts as one; lengths past the cell count saturate.
    always_comb
    begin
        priority if (length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (length_reg > PMAX_LEN)
        begin
            eff_len = PMAX_LEN;
        end
        else
        begin
            eff_len = length_reg;
        end
    end

    assign accept = s_tvalid & s_tready;
    assign chain[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            assign in_use[gi] = LEN_W'(gi) < eff_len;
            assign is_top[gi] = LEN_W'(gi + 1) == eff_len;

            wbps_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .advance      (accept),
                .clear        (clear),
                .pattern_byte (pattern_reg[gi / 8][(gi % 8) * 8 +: 8]),
                .wild         (wildcard_reg[gi]),
                .in_use       (in_use[gi]),
                .data_byte    (s_tdata),
                .prev_bit     (chain[gi]),
                .cur_bit      (cur_bits[gi]),
                .state_bit    (state_bits[gi])
            );

            assign chain[gi + 1] = state_bits[gi];
        end
    endgenerate

    assign full_match = |(cur_bits & is_top);
    assign report     = full_match & (find_all_reg | ~found_reg);
    // A full match always restarts the scan, reported or not.
    assign clear      = full_match | s_tlast;

    assign start_off = pos_reg - OFFSET_WIDTH'(eff_len - LEN_W'(1));
    assign start_ext = {{MATCH_OFF_W{1'b0}}, start_off};

    always_comb
    begin
        res.match_valid  = report;
        res.match_offset = report ? start_ext[MATCH_OFF_W-1:0] : '0;
        res.section_end  = s_tlast;
        res.any_found    = s_tlast & (found_reg | report);
    end

    always_comb
    begin
        pos_next   = pos_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next   = '0;
                found_next = 1'b0;
            end
            else
            begin
                pos_next   = pos_reg + OFFSET_WIDTH'(1);
                found_next = found_reg | report;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    wbps_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept & (report | s_tlast)),
        .push_data  (res),
        .can_accept (buf_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign s_tready = buf_ready;
    assign m_tdata  = {{(OUT_TDATA_W - MATCH_OFF_W - 2){1'b0}},
                       out_res.any_found, out_res.match_offset, out_res.match_valid};
    assign m_tlast  = out_res.section_end;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the wildcard byte pattern scanner unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wbps_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned RECV_HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT      = 4000;
    localparam int unsigned ROUND_BYTES      = 90;
    localparam int unsigned NUM_ROUNDS       = 12;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } scan_word_t;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   cfg_wr_en  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata    = '0;
    logic                   s_tlast    = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    wildcard_byte_pattern_scanner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the configuration registers.
    logic [255:0] cfg_pat  = '0;
    logic [31:0]  cfg_wild = '0;
    logic [5:0]   cfg_len  = 6'd1;
    logic         cfg_all  = 1'b0;

    // Shadow copy of the scan state.
    logic [31:0]  scan_vec   = '0;
    logic [31:0]  scan_pos   = '0;
    logic         scan_found = 1'b0;

    scan_word_t   byte_queue[$];
    result_t      pending_reports[$];

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    logic         recv_hold_go  = 1'b0;
    int unsigned  recv_hold_cnt = 0;

    int unsigned  mismatch_count  = 0;
    int unsigned  reports_checked = 0;
    int unsigned  matches_seen    = 0;
    int unsigned  bytes_sent      = 0;
    int unsigned  sections_queued = 0;
    int unsigned  settings_used   = 0;
    int unsigned  stall_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned eff_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > 32)
            return 32;
        return cfg_len;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned i);
        return cfg_pat[i*8 +: 8];
    endfunction

    // Updates the scan state for one accepted byte and queues the result word it causes.
    function automatic void advance_scan(input logic [7:0] b, input logic lst);
        int unsigned n;
        logic [31:0] hits;
        logic [31:0] top;
        logic [31:0] nxt;
        logic        hit_end;
        result_t     r;
        n = eff_len();
        hits = '0;
        for (int i = 0; i < n; i++)
            if (cfg_wild[i] || pat_byte(i) == b)
                hits[i] = 1'b1;
        top = 32'd1 << (n - 1);
        nxt = ((scan_vec << 1) | 32'd1) & hits & ((top - 32'd1) | top);
        hit_end = 1'b0;
        r = '0;
        if ((nxt & top) != 0)
        begin
            if (cfg_all || !scan_found)
            begin
                hit_end = 1'b1;
                r.match_offset = scan_pos - (n - 1);
                scan_found = 1'b1;
            end
            nxt = '0;
        end
        scan_vec = nxt;
        if (hit_end || lst)
        begin
            r.match_valid = hit_end;
            r.section_end = lst;
            r.any_found   = lst && scan_found;
            pending_reports.insert(pending_reports.size(), r);
        end
        if (lst)
        begin
            scan_vec   = '0;
            scan_pos   = '0;
            scan_found = 1'b0;
        end
        else
            scan_pos = scan_pos + 1;
    endfunction

    task automatic check_report();
        result_t want;
        if (pending_reports.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("tb_top: unexpected result word tdata=%h tlast=%b", m_tdata, m_tlast);
        end
        else
        begin
            want = pending_reports.pop_front();
            if (m_tdata[0] !== want.match_valid || m_tdata[32:1] !== want.match_offset ||
                m_tlast !== want.section_end || m_tdata[33] !== want.any_found ||
                m_tdata[39:34] !== '0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("tb_top: mismatch exp valid=%b off=%h end=%b any=%b",
                             want.match_valid, want.match_offset, want.section_end,
                             want.any_found);
                    $display("tb_top:          got valid=%b off=%h end=%b any=%b pad=%h",
                             m_tdata[0], m_tdata[32:1], m_tlast, m_tdata[33],
                             m_tdata[39:34]);
                end
            end
        end
        reports_checked++;
        if (m_tdata[0])
            matches_seen++;
    endtask

    // Byte driver: offers the next queued byte and feeds accepted ones to the predictor.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        scan_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_scan(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.data;
                    s_tlast  <= w.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word and throttles m_tready.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_report();
            if (recv_hold_go && recv_hold_cnt < RECV_HOLD_CYCLES)
            begin
                recv_hold_cnt <= recv_hold_cnt + 1;
                m_tready      <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: no progress for %0d cycles", stall_cycles);
                $display("tb_top: FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PATTERN_0: cfg_pat[63:0]    = val;
            REG_PATTERN_1: cfg_pat[127:64]  = val;
            REG_PATTERN_2: cfg_pat[191:128] = val;
            REG_PATTERN_3: cfg_pat[255:192] = val;
            REG_WILDCARD:  cfg_wild = val[31:0];
            REG_LENGTH:    cfg_len  = val[5:0];
            REG_FIND_ALL:  cfg_all  = val[0];
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic lst);
        scan_word_t w;
        w.data = b;
        w.last = lst;
        byte_queue.insert(byte_queue.size(), w);
        if (lst)
            sections_queued++;
    endtask

    // Sampled on the falling edge so that the driver's updates have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (byte_queue.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_pattern_byte();
        case ($urandom_range(7))
            0, 1:    return 8'h00;
            2:       return 8'hFF;
            3, 4, 5: return 8'(8'h41 + $urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Copies of the pattern (some cut short) mixed with noise bytes.
    task automatic queue_section(input int unsigned sec_len);
        int unsigned k;
        int unsigned cut;
        int unsigned n;
        n = eff_len();
        k = 0;
        while (k < sec_len)
        begin
            if ($urandom_range(99) < 40)
            begin
                cut = n;
                if (n > 1 && $urandom_range(4) == 0)
                    cut = $urandom_range(n - 1, 1);
                for (int j = 0; j < cut && k < sec_len; j++)
                begin
                    push_byte(cfg_wild[j] ? 8'($urandom_range(255)) : pat_byte(j),
                              k == sec_len - 1);
                    k++;
                end
            end
            else
            begin
                push_byte($urandom_range(1) ? 8'(8'h41 + $urandom_range(3))
                                            : 8'($urandom_range(255)), k == sec_len - 1);
                k++;
            end
        end
    endtask

    task automatic run_round(input int unsigned r);
        cfg_reg_t    pattern_regs[4];
        logic [63:0] w;
        logic [31:0] wild;
        logic [5:0]  len_val;
        int unsigned n;
        int unsigned sec_len;
        int unsigned round_items;
        pattern_regs = '{REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3};
        for (int q = 0; q < 4; q++)
        begin
            for (int j = 0; j < 8; j++)
                w[j*8 +: 8] = rand_pattern_byte();
            write_reg(pattern_regs[q], w);
        end
        wild = '0;
        if (r == 2)
            wild = '1;
        else if (r != 1)
            for (int j = 0; j < 32; j++)
                wild[j] = ($urandom_range(4) == 0);
        write_reg(REG_WILDCARD, {32'($urandom), wild});
        case (r)
            0:       len_val = 6'd1;
            1:       len_val = 6'd32;
            2:       len_val = 6'd63;
            3:       len_val = 6'd33;
            5:       len_val = 6'd0;
            default:
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: len_val = 6'($urandom_range(6, 1));
                    5, 6, 7:       len_val = 6'($urandom_range(16, 7));
                    default:       len_val = 6'($urandom_range(32, 17));
                endcase
            end
        endcase
        write_reg(REG_LENGTH, {26'($urandom), 32'($urandom), len_val});
        w = {32'($urandom), 32'($urandom)};
        write_reg(REG_FIND_ALL, w);
        if ($urandom_range(2) == 0)
            write_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
        settings_used++;

        // Receiver throttled harder first, then sender throttled harder, then free-running.
        if (r < NUM_ROUNDS / 3)
        begin
            send_idle_pct = 36;
            recv_idle_pct = 69;
        end
        else if (r < 2 * NUM_ROUNDS / 3)
        begin
            send_idle_pct = 69;
            recv_idle_pct = 36;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end

        n = eff_len();
        round_items = 0;
        while (round_items < ROUND_BYTES)
        begin
            if ($urandom_range(7) == 0)
                sec_len = $urandom_range(3 * n + 8, n);
            else
                sec_len = $urandom_range(n + 12, 1);
            queue_section(sec_len);
            round_items += sec_len;
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 69;

        // Reset setting: single byte 0x00, first match only, extremes of the byte range.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // Zero length acts as one byte; find-all with junk in the upper bits.
        write_reg(REG_PATTERN_0, 64'h0000_0000_0000_00FF);
        write_reg(REG_LENGTH, 64'h0);
        write_reg(REG_FIND_ALL, 64'hFFFF_FFFF_FFFF_FFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // "A?C" in single mode: the second hit lands on the last byte and is suppressed.
        // The write to the unused index must change nothing.
        write_reg(REG_PATTERN_0, 64'h0000_0000_0043_0041);
        write_reg(REG_WILDCARD, 64'hFFFF_FFFF_0000_0002);
        write_reg(REG_LENGTH, 64'h3);
        write_reg(REG_FIND_ALL, 64'h0);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        push_byte(8'h41, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h43, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h43, 1'b1);
        wait_idle();

        // Every byte matches, so the output backs up while the receiver holds off.
        write_reg(REG_WILDCARD, 64'h1);
        write_reg(REG_LENGTH, 64'h1);
        write_reg(REG_FIND_ALL, 64'h1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 60; i++)
            push_byte(8'($urandom_range(255)), i % 30 == 29);
        @(negedge clk);
        recv_hold_go = 1'b1;
        wait_idle();

        for (int r = 0; r < NUM_ROUNDS; r++)
            run_round(r);

        if (pending_reports.size() != 0)
        begin
            mismatch_count += pending_reports.size();
            $display("tb_top: %0d result words never arrived", pending_reports.size());
        end
        $display("tb_top: %0d bytes in %0d sections, %0d result words checked, %0d matches",
                 bytes_sent, sections_queued, reports_checked, matches_seen);
        $display("tb_top: %0d random pattern settings incl. zero and oversized lengths",
                 settings_used);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/wbps_pkg.sv
design/wbps_cell.sv
design/wbps_out_buf.sv
design/wildcard_byte_pattern_scanner_unit.sv
dv/tb_top.sv
